// ===== rtl/swmm_pkg.sv =====
// Shared types and constants for the sliding-window min/max block.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package swmm_pkg;

    // Deepest window the cell row supports (one cell per sample of age).
    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;

    // Configured window size register and the clamped size actually used.
    localparam int WINDOW_SIZE_W     = 7;
    localparam int WINDOW_SIZE_RESET = 3;
    localparam int K_W               = $clog2(WINDOW_MAX + 1);

    // Count of samples since start of sequence, saturating.
    localparam int FILL_W   = 7;
    localparam int FILL_SAT = (1 << FILL_W) - 1;

    // APB register map: register i at byte address 4*i.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_IDX_WINDOW_SIZE = '0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [K_W-1:0]             t_win;
    typedef logic [FILL_W-1:0]          t_fill;

    // One stored sample with its membership in the min and max queues.
    typedef struct packed {
        t_sample value;
        logic    min_alive;
        logic    max_alive;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/swmm_in_if.sv =====
// Input channel: one sample word plus start-of-sequence flag.
// Depends on swmm_pkg.
`default_nettype none

interface swmm_in_if;
    logic               valid;
    logic               ready;
    swmm_pkg::t_sample  sample;
    logic               start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

`default_nettype wire

// ===== rtl/swmm_out_if.sv =====
// Output channel: window minimum and maximum word.
// Depends on swmm_pkg.
`default_nettype none

interface swmm_out_if;
    logic               valid;
    logic               ready;
    swmm_pkg::t_sample  window_min;
    swmm_pkg::t_sample  window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

`default_nettype wire

// ===== rtl/swmm_apb_regs.sv =====
// APB configuration register: window size.
// Depends on swmm_pkg.
`default_nettype none

module swmm_apb_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swmm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [swmm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [swmm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output logic      [swmm_pkg::WINDOW_SIZE_W-1:0] o_window_size
);
    import swmm_pkg::*;

    logic                     w_sel_ws;
    logic [WINDOW_SIZE_W-1:0] r_window_size;

    // Low address bits are byte offsets inside the word and are ignored.
    assign w_sel_ws = (paddr[APB_ADDR_W-1:2] == REG_IDX_WINDOW_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_W'(WINDOW_SIZE_RESET);
        end else if (psel && penable && pwrite && pready && w_sel_ws) begin
            r_window_size <= pwdata[WINDOW_SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_ws) begin
            prdata = {{(APB_DATA_W-WINDOW_SIZE_W){1'b0}}, r_window_size};
        end
    end

    assign pready        = 1'b1;
    assign o_window_size = r_window_size;

endmodule

`default_nettype wire

// ===== rtl/swmm_cell.sv =====
// One cell of the sample shift row: holds a sample and its queue membership.
// Depends on swmm_pkg.
`default_nettype none

module swmm_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,    // word accepted: shift row by one
    input  wire logic              i_flush,   // start of sequence: drop all entries
    input  wire logic              i_keep,    // entry still inside window after shift
    input  wire swmm_pkg::t_sample i_sample,  // incoming sample
    input  wire swmm_pkg::t_entry  i_up,      // survivor from younger neighbor
    output swmm_pkg::t_entry       o_down,    // survivor handed to older neighbor
    output swmm_pkg::t_entry       o_entry    // current contents
);
    import swmm_pkg::*;

    t_sample r_value;
    logic    r_min_alive;
    logic    r_max_alive;
    logic    w_dom_min;
    logic    w_dom_max;

    // Newer sample at or below (above) this one evicts it; ties keep newest.
    assign w_dom_min = ($signed(r_value) >= $signed(i_sample));
    assign w_dom_max = ($signed(r_value) <= $signed(i_sample));

    always_comb begin
        o_down.value     = r_value;
        o_down.min_alive = r_min_alive & i_keep & ~w_dom_min & ~i_flush;
        o_down.max_alive = r_max_alive & i_keep & ~w_dom_max & ~i_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_alive <= 1'b0;
            r_max_alive <= 1'b0;
        end else if (i_step) begin
            r_min_alive <= i_up.min_alive;
            r_max_alive <= i_up.max_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_value <= i_up.value;
        end
    end

    assign o_entry = '{value: r_value, min_alive: r_min_alive, max_alive: r_max_alive};

endmodule

`default_nettype wire

// ===== rtl/swmm_front_sel.sv =====
// Queue front pick: oldest live entry of each queue, muxed out one-hot.
// Depends on swmm_pkg.
`default_nettype none

module swmm_front_sel (
    input  wire swmm_pkg::t_entry i_cells [swmm_pkg::WINDOW_MAX],
    output swmm_pkg::t_sample     o_min,
    output swmm_pkg::t_sample     o_max
);
    import swmm_pkg::*;

    logic [WINDOW_MAX-1:0] w_min_mask;
    logic [WINDOW_MAX-1:0] w_max_mask;
    logic [WINDOW_MAX-1:0] w_min_sel;
    logic [WINDOW_MAX-1:0] w_max_sel;

    // Higher index = older sample; front is the highest live index.
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_min_mask[i] = i_cells[i].min_alive;
            w_max_mask[i] = i_cells[i].max_alive;
        end
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_min_sel[i] = w_min_mask[i] & ((w_min_mask >> (i + 1)) == '0);
            w_max_sel[i] = w_max_mask[i] & ((w_max_mask >> (i + 1)) == '0);
        end
    end

    always_comb begin
        o_min = '0;
        o_max = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            o_min = o_min | ({SAMPLE_W{w_min_sel[i]}} & i_cells[i].value);
            o_max = o_max | ({SAMPLE_W{w_max_sel[i]}} & i_cells[i].value);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max.sv =====
// Sliding-window min/max: row of WINDOW_MAX aging cells, min and max queues as live bits.
// Throughput: 1 sample per cycle unless a pending result waits behind a blocked output;
// the cell row shifts once per accepted word, and the front pick sits between the cell
// registers and the output register.
// Reset (i_rst_n low, synchronous): queues empty, fill count zero, window size 3;
// sample values in cells are not reset and are never read while not live.
`default_nettype none

module sliding_window_min_max (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    swmm_in_if.sink                              in_ch,
    swmm_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swmm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [swmm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [swmm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import swmm_pkg::*;

    localparam int LAST = WINDOW_MAX - 1;

    logic [WINDOW_SIZE_W-1:0] w_window_size;
    t_win                     w_k;          // clamped window size, 1..WINDOW_MAX
    logic                     w_accept;
    logic                     w_out_blocked;
    logic                     w_due;        // this word produces a result
    t_fill                    r_fill;
    t_fill                    n_fill;
    logic                     r_pend;       // result waiting for front pick
    logic                     r_out_valid;
    t_sample                  r_out_min;
    t_sample                  r_out_max;
    t_sample                  w_front_min;
    t_sample                  w_front_max;
    t_entry                   w_up    [WINDOW_MAX];
    t_entry                   w_down  [WINDOW_MAX];
    t_entry                   w_cells [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]    w_keep;
    logic [WINDOW_MAX-1:0]    w_min_live;

    // ---------------- configuration ----------------
    swmm_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_window_size (w_window_size)
    );

    // Zero means 1; anything past the row length means the full row.
    always_comb begin
        if (w_window_size == '0) begin
            w_k = K_W'(1);
        end else if (int'(w_window_size) > WINDOW_MAX) begin
            w_k = K_W'(WINDOW_MAX);
        end else begin
            w_k = K_W'(w_window_size);
        end
    end

    // ---------------- handshake ----------------
    // A pending result only stalls input when the output register cannot take it.
    assign w_out_blocked = r_out_valid && !out_ch.ready;
    assign in_ch.ready   = !(r_pend && w_out_blocked);
    assign w_accept      = in_ch.valid && in_ch.ready;

    // Fill count restarts with the sequence and saturates.
    always_comb begin
        n_fill = in_ch.start_of_sequence ? '0 : r_fill;
        if (int'(n_fill) < FILL_SAT) begin
            n_fill = n_fill + t_fill'(1);
        end
    end

    assign w_due = (int'(n_fill) >= int'(w_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill <= n_fill;
                r_pend <= w_due;
            end else if (!w_out_blocked) begin
                r_pend <= 1'b0;
            end
        end
    end

    // ---------------- cell row ----------------
    // Cell i holds the sample of age i. A cell's entry survives into cell i+1
    // only if it is still inside the window after the shift and the new
    // sample does not dominate it. The new sample always enters both queues.
    assign w_up[0] = '{value: in_ch.sample, min_alive: 1'b1, max_alive: 1'b1};

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        assign w_keep[g]     = ((32'(g) + 32'd1) < 32'(w_k));
        assign w_min_live[g] = w_cells[g].min_alive;

        if (g > 0) begin : g_link
            assign w_up[g] = w_down[g-1];
        end

        swmm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_accept),
            .i_flush  (in_ch.start_of_sequence),
            .i_keep   (w_keep[g]),
            .i_sample (in_ch.sample),
            .i_up     (w_up[g]),
            .o_down   (w_down[g]),
            .o_entry  (w_cells[g])
        );
    end

    // ---------------- front pick and output register ----------------
    swmm_front_sel u_front (
        .i_cells (w_cells),
        .o_min   (w_front_min),
        .o_max   (w_front_max)
    );

    // Cells still hold the pending word's state in the cycle after accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && !w_out_blocked) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && !w_out_blocked) begin
            r_out_min <= w_front_min;
            r_out_max <= w_front_max;
        end
    end

    assign out_ch.valid      = r_out_valid;
    assign out_ch.window_min = r_out_min;
    assign out_ch.window_max = r_out_max;

    // ---------------- assertions ----------------
    // Oldest cell never hands a live entry off the end of the row.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_down[LAST].min_alive || w_down[LAST].max_alive))
        else $error("live entry shifted past last cell");

    // Start of sequence leaves only the new sample in the min queue.
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && in_ch.start_of_sequence |=> $countones(w_min_live) == 1)
        else $error("min queue not cleared on start of sequence");

    // Newest sample always enters both queues.
    a_new_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_cells[0].min_alive && w_cells[0].max_alive))
        else $error("new sample missing from a queue");

    // Window minimum never exceeds window maximum.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> ($signed(out_ch.window_min) <= $signed(out_ch.window_max)))
        else $error("window min above window max");

    // A pending result held behind a full output is not dropped.
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && w_out_blocked |=> r_pend)
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for sliding_window_min_max: drives sample words and APB window writes,
// predicts window min/max in a scoreboard class and compares every result word.
// Depends on swmm_pkg, swmm_in_if, swmm_out_if and the sliding_window_min_max RTL.

module testbench;
    import swmm_pkg::*;

    localparam int NUM_PHASES     = 9;
    localparam int PHASE_WORDS    = 100;
    localparam int SETTLE_CYCLES  = 6;      // margin after each drain
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no word moving on either side
    localparam logic [APB_ADDR_W-1:0] WINDOW_SIZE_ADDR = {REG_IDX_WINDOW_SIZE, 2'b00};

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // One queue entry: sample value with the position it was taken at.
    typedef struct {
        t_sample   value;
        bit [31:0] pos;
    } t_slot;

    typedef struct {
        t_sample lo;
        t_sample hi;
    } t_extremes;

    // Tracks both monotonic deques and the expected min/max result words.
    class minmax_scoreboard;
        t_slot                  lo_deque[$];
        t_slot                  hi_deque[$];
        t_extremes              expected_extremes[$];
        bit [WINDOW_SIZE_W-1:0] window_reg;
        bit [31:0]              next_pos;
        int                     fill;
        int                     errors;

        function new();
            window_reg = WINDOW_SIZE_W'(WINDOW_SIZE_RESET);
            next_pos   = '0;
            fill       = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_extremes.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        // Accepted input word: update both deques, queue a result once the window is full.
        function void take_sample(t_sample s, logic sos);
            int unsigned span;
            t_slot       slot;
            t_extremes   ext;
            span = (window_reg == 0) ? 1 :
                   (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
            if (sos) begin
                lo_deque.delete();
                hi_deque.delete();
                next_pos = '0;
                fill     = 0;
            end
            // drop entries that fell out of the (possibly just shrunk) window
            while (lo_deque.size() > 0 && (next_pos - lo_deque[0].pos) >= span)
                lo_deque.delete(0);
            while (hi_deque.size() > 0 && (next_pos - hi_deque[0].pos) >= span)
                hi_deque.delete(0);
            // dominated tails go; ties drop the older entry
            while (lo_deque.size() > 0 && lo_deque[$].value >= s)
                lo_deque.delete(lo_deque.size() - 1);
            while (hi_deque.size() > 0 && hi_deque[$].value <= s)
                hi_deque.delete(hi_deque.size() - 1);
            slot.value = s;
            slot.pos   = next_pos;
            lo_deque.insert(lo_deque.size(), slot);
            hi_deque.insert(hi_deque.size(), slot);
            next_pos++;
            if (fill < FILL_SAT)
                fill++;
            if (fill >= span) begin
                ext.lo = lo_deque[0].value;
                ext.hi = hi_deque[0].value;
                expected_extremes.insert(expected_extremes.size(), ext);
            end
        endfunction

        task check_extremes(t_sample got_min, t_sample got_max);
            t_extremes want;
            if (expected_extremes.size() == 0) begin
                report_mismatch($sformatf("result word min %0d max %0d with none expected",
                                          got_min, got_max));
                return;
            end
            want = expected_extremes[0];
            expected_extremes.delete(0);
            if (got_min !== want.lo)
                report_mismatch($sformatf("window_min expected %0d got %0d", want.lo, got_min));
            if (got_max !== want.hi)
                report_mismatch($sformatf("window_max expected %0d got %0d", want.hi, got_max));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    swmm_in_if  in_ch();
    swmm_out_if out_ch();

    minmax_scoreboard sb;

    int      send_idle_pct;   // chance per cycle that the sender holds off
    int      recv_stall_pct;  // chance per cycle that ready is low
    int      quiet_cycles;
    t_sample last_sample;

    // Directed opening: reset window of 3, extremes, ties, ramps, restarts.
    t_sample dir_samples[24] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
        32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
        32'sh7fffffff, 32'sh7fffffff, 1, 2,
        3, 4, 3, 2,
        1, 5, 5, -5,
        10, 20, 32'sh55555555, 32'shaaaaaaaa
    };
    bit dir_sos[24] = '{
        1, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0,
        0, 1, 0, 1, 0, 0, 0, 0
    };

    t_sample edge_values[4] = '{32'sh80000000, 32'sh7fffffff, 32'sh00000000, 32'shffffffff};

    // Window settings per phase; phases 6 and 7 get a random size instead.
    bit [WINDOW_SIZE_W-1:0] phase_windows[NUM_PHASES] = '{1, 64, 0, 127, 65, 2, 0, 0, 3};

    sliding_window_min_max u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready re-rolled every cycle from the current stall rate.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: input word noted before the output word of the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready === 1'b1)
                sb.take_sample(in_ch.sample, in_ch.start_of_sequence);
            if (out_ch.valid === 1'b1 && out_ch.ready)
                sb.check_extremes(out_ch.window_min, out_ch.window_max);
        end
    end

    // Watchdog: any word moving on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one word, with a random hold-off first, and return at its accepting edge.
    task automatic send_word(input t_sample s, input bit sos);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid             <= 1'b1;
        in_ch.sample            <= s;
        in_ch.start_of_sequence <= sos;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Stop sending and wait for every expected word; the first edge lets the
    // monitor log a word accepted on the edge we were called at.
    task automatic wait_drained(input int settle);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read back in the access phase; prdata sampled mid-cycle to stay clear of the edge.
    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [WINDOW_SIZE_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        if (prdata[WINDOW_SIZE_W-1:0] !== want)
            sb.report_mismatch($sformatf("window_size read %0d, wrote %0d",
                                         prdata[WINDOW_SIZE_W-1:0], want));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Window change only with the pipe empty; no restart, so it lands mid-stream.
    task automatic set_window(input bit [WINDOW_SIZE_W-1:0] win_size);
        wait_drained(SETTLE_CYCLES);
        apb_write(WINDOW_SIZE_ADDR, APB_DATA_W'(win_size));
        sb.window_reg = win_size;
        apb_read_check(WINDOW_SIZE_ADDR, win_size);
    endtask

    // Random sample mix: full-range words, a narrow band for ties, extremes, slow ramps.
    function automatic t_sample next_sample();
        t_sample s;
        case ($urandom_range(9))
            0, 1, 2, 3: s = $urandom;
            4, 5, 6:    s = $signed($urandom_range(8)) - 4;
            7:          s = edge_values[$urandom_range(3)];
            default:    s = last_sample + $signed($urandom_range(6)) - 3;
        endcase
        last_sample = s;
        return s;
    endfunction

    task automatic set_idle_mode(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 56 : (mode == IDLE_BOTH) ? 16 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 56 : (mode == IDLE_BOTH) ? 16 : 0;
    endtask

    initial begin
        bit [WINDOW_SIZE_W-1:0] win_size;
        bit                     sos;

        sb             = new();
        last_sample    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n                 <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.sample            <= '0;
        in_ch.start_of_sequence <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words run on the reset window size, nothing written yet.
        foreach (dir_samples[i])
            send_word(dir_samples[i], dir_sos[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            win_size = phase_windows[p];
            if (p == 6)
                win_size = WINDOW_SIZE_W'($urandom_range(64, 1));
            else if (p == 7)
                win_size = WINDOW_SIZE_W'($urandom_range(12, 4));
            set_window(win_size);
            set_idle_mode(t_idle_mode'(p % 4));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // sender backs off until the result side is empty
                if (n == PHASE_WORDS / 2)
                    wait_drained(0);
                sos = (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0);
                send_word(next_sample(), sos);
            end
        end

        set_idle_mode(IDLE_NONE);
        wait_drained(SETTLE_CYCLES);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/swmm_pkg.sv
rtl/swmm_in_if.sv
rtl/swmm_out_if.sv
rtl/swmm_apb_regs.sv
rtl/swmm_cell.sv
rtl/swmm_front_sel.sv
rtl/sliding_window_min_max.sv
sim/testbench.sv
